// ===== design/murmur3_hash_32_unit_assert.svh =====
// Assertion macros used by the checker file of the hash unit.
`ifndef MURMUR3_HASH_32_UNIT_ASSERT_SVH
`define MURMUR3_HASH_32_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MM3H_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("mm3h: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MM3H_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("mm3h: next-cycle check failed");

`endif

// ===== design/mm3h_pkg.sv =====
`default_nettype none

package mm3h_pkg;

  // Block mix and fold constants.
  localparam logic [31:0] MIX_C1   = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2   = 32'h1b873593;
  localparam logic [31:0] FOLD_ADD = 32'he6546b64;

  // Finalizer constants.
  localparam logic [31:0] FIN_M1 = 32'h85ebca6b;
  localparam logic [31:0] FIN_M2 = 32'hc2b2ae35;

  localparam logic [31:0] SEED_RESET = 32'd1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX1,
    ST_MIX2,
    ST_MERGE,
    ST_FIN1,
    ST_FIN2,
    ST_FIN3
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mix1;
    logic mix2;
    logic fold;
    logic tail;
    logic fin1;
    logic fin2;
    logic fin3;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic block_full;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== design/mm3h_ctrl.sv =====
`default_nettype none

module mm3h_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_last_byte,
  output logic                   in_ready,
  input  wire mm3h_pkg::status_t status,
  output mm3h_pkg::cmd_t         cmd
);

  mm3h_pkg::state_t state_r, state_nxt;
  logic             block_r, block_nxt;
  logic             last_r, last_nxt;

  // State and mode registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mm3h_pkg::ST_IDLE;
      block_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      block_r <= block_nxt;
      last_r  <= last_nxt;
    end
  end

  // Next state: a full block or a last byte starts the mixing sequence; a last byte then goes on to the finalizer.
  always_comb begin
    state_nxt = state_r;
    block_nxt = block_r;
    last_nxt  = last_r;
    case (state_r)
      mm3h_pkg::ST_IDLE: begin
        if (in_valid) begin
          block_nxt = status.block_full;
          last_nxt  = in_last_byte;
          if (status.block_full || in_last_byte) begin
            state_nxt = mm3h_pkg::ST_MIX1;
          end
        end
      end
      mm3h_pkg::ST_MIX1:  state_nxt = mm3h_pkg::ST_MIX2;
      mm3h_pkg::ST_MIX2:  state_nxt = mm3h_pkg::ST_MERGE;
      mm3h_pkg::ST_MERGE: begin
        if (block_r && !last_r) begin
          state_nxt = mm3h_pkg::ST_IDLE;
        end else begin
          state_nxt = mm3h_pkg::ST_FIN1;
        end
      end
      mm3h_pkg::ST_FIN1:  state_nxt = mm3h_pkg::ST_FIN2;
      mm3h_pkg::ST_FIN2:  state_nxt = mm3h_pkg::ST_FIN3;
      mm3h_pkg::ST_FIN3: begin
        if (status.out_free) begin
          state_nxt = mm3h_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mm3h_pkg::ST_IDLE;
    endcase
  end

  // Outputs: one datapath command per state.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      mm3h_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      mm3h_pkg::ST_MIX1:  cmd.mix1 = 1'b1;
      mm3h_pkg::ST_MIX2:  cmd.mix2 = 1'b1;
      mm3h_pkg::ST_MERGE: begin
        cmd.fold = block_r;
        cmd.tail = !block_r;
      end
      mm3h_pkg::ST_FIN1:  cmd.fin1 = 1'b1;
      mm3h_pkg::ST_FIN2:  cmd.fin2 = 1'b1;
      mm3h_pkg::ST_FIN3:  cmd.fin3 = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/mm3h_dpath.sv =====
`default_nettype none

module mm3h_dpath (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_wr_en,
  input  wire logic [31:0]    cfg_wr_data,
  input  wire logic [7:0]     in_data_byte,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [31:0]         out_hash_value,
  input  wire mm3h_pkg::cmd_t cmd,
  output mm3h_pkg::status_t   status
);

  logic [31:0] seed_r;
  logic [31:0] hash_r, hash_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [31:0] len_r, len_nxt;
  logic        in_msg_r, in_msg_nxt;
  logic [31:0] work_r, work_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_hash_r, out_hash_nxt;

  logic [31:0] acc_new;
  logic [31:0] hash_base;
  logic [31:0] merge_x;
  logic [31:0] fin_x;
  logic [31:0] mul_a, mul_b, mul_p;

  // Byte packing: little-endian placement by byte position.
  assign acc_new   = acc_r | ({24'd0, in_data_byte} << {pos_r, 3'b000});
  assign hash_base = in_msg_r ? hash_r : seed_r;
  assign merge_x   = hash_r ^ work_r;
  assign fin_x     = hash_r ^ len_r;

  assign status.block_full = (pos_r == 2'd3);
  assign status.out_free   = !out_valid_r || out_ready;

  // Shared 32x32 multiplier, low half of the product.
  always_comb begin
    mul_a = work_r;
    mul_b = mm3h_pkg::MIX_C1;
    if (cmd.mix2) begin
      mul_a = {work_r[16:0], work_r[31:17]};
      mul_b = mm3h_pkg::MIX_C2;
    end else if (cmd.fin1) begin
      mul_a = fin_x ^ {16'd0, fin_x[31:16]};
      mul_b = mm3h_pkg::FIN_M1;
    end else if (cmd.fin2) begin
      mul_a = work_r ^ {13'd0, work_r[31:13]};
      mul_b = mm3h_pkg::FIN_M2;
    end
  end

  assign mul_p = mul_a * mul_b;

  // Message state and work register updates.
  always_comb begin
    logic [31:0] rot;
    rot           = {merge_x[18:0], merge_x[31:19]};
    hash_nxt      = hash_r;
    acc_nxt       = acc_r;
    pos_nxt       = pos_r;
    len_nxt       = len_r;
    in_msg_nxt    = in_msg_r;
    work_nxt      = work_r;
    out_hash_nxt  = out_hash_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.load) begin
      hash_nxt   = hash_base;
      in_msg_nxt = 1'b1;
      len_nxt    = len_r + 32'd1;
      pos_nxt    = pos_r + 2'd1;
      work_nxt   = acc_new;
      acc_nxt    = (pos_r == 2'd3) ? 32'd0 : acc_new;
    end
    if (cmd.mix1 || cmd.mix2 || cmd.fin1 || cmd.fin2) begin
      work_nxt = mul_p;
    end
    // Fold: times five is a shift and add.
    if (cmd.fold) begin
      hash_nxt = rot + {rot[29:0], 2'b00} + mm3h_pkg::FOLD_ADD;
    end
    if (cmd.tail) begin
      hash_nxt = merge_x;
    end
    // Last finalizer step goes to the output register and ends the message.
    if (cmd.fin3) begin
      out_hash_nxt  = work_r ^ {16'd0, work_r[31:16]};
      out_valid_nxt = 1'b1;
      acc_nxt       = 32'd0;
      pos_nxt       = 2'd0;
      len_nxt       = 32'd0;
      in_msg_nxt    = 1'b0;
    end
  end

  // Control-state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= mm3h_pkg::SEED_RESET;
      acc_r       <= 32'd0;
      pos_r       <= 2'd0;
      len_r       <= 32'd0;
      in_msg_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
      acc_r       <= acc_nxt;
      pos_r       <= pos_nxt;
      len_r       <= len_nxt;
      in_msg_r    <= in_msg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    hash_r     <= hash_nxt;
    work_r     <= work_nxt;
    out_hash_r <= out_hash_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

endmodule

`default_nettype wire

// ===== design/murmur3_hash_32_unit.sv =====
// MurmurHash3 x86_32 over a byte stream, one byte per input beat, with the
// seed taken from the cfg register (reset value 1) at the first byte of each
// message. A byte that does not complete a 4-byte block is packed into the
// block, and the unit stays ready for the next byte. A byte that completes a
// block is accepted, then goes through the block mix and fold in three steps
// through one shared 32x32 multiplier. The last byte of a message is accepted,
// then goes through the block or tail mix and the finalizer, after which the
// hash is placed in the output register. The last finalizer cycle is held for
// as long as an earlier hash still waits in the output register and is not
// taken in that cycle. The next message may start while a result beat still
// waits to be taken. A seed write takes effect from the next message; the
// message in progress keeps the seed it started with.
`default_nettype none

module murmur3_hash_32_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_hash_value
);

  mm3h_pkg::cmd_t    cmd;
  mm3h_pkg::status_t status;

  // Sequencer.
  mm3h_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_byte (in_last_byte),
    .in_ready     (in_ready),
    .status       (status),
    .cmd          (cmd)
  );

  // Hash state, shared multiplier and output register.
  mm3h_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value),
    .cmd            (cmd),
    .status         (status)
  );

endmodule

`default_nettype wire

// ===== design/mm3h_checker.sv =====
`default_nettype none

`include "murmur3_hash_32_unit_assert.svh"

module mm3h_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_last_byte,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_hash_value
);

  logic in_fire_last;

  assign in_fire_last = in_valid && in_ready && in_last_byte;

  // A waiting result beat holds its value.
  `MM3H_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_hash_value))

  // The last byte of a message always starts the mixing sequence.
  `MM3H_ASSERT_NEXT(a_last_busy, clk, rst_n, in_fire_last, !in_ready ##1 !in_ready)

  // A new result only appears after a busy cycle of the finalizer.
  `MM3H_ASSERT_NOW(a_out_after_busy, clk, rst_n, $rose(out_valid), !$past(in_ready))

endmodule

bind murmur3_hash_32_unit mm3h_checker u_mm3h_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_last_byte   (in_last_byte),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_hash_value (out_hash_value)
);

`default_nettype wire
